// ===== design/grid_word_search_four_dir_top_assert.svh =====
// Assertion macros for the top-level file, which checks its own logic.
`ifndef GRID_WORD_SEARCH_FOUR_DIR_TOP_ASSERT_SVH
`define GRID_WORD_SEARCH_FOUR_DIR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define GWS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define GWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gws_pkg.sv =====
`timescale 1ns / 1ps

package gws_pkg;

    // Grid geometry.
    localparam int GRID_SIZE   = 16;
    localparam int GRID_BITS   = $clog2(GRID_SIZE);
    localparam int GRID_ADDR_W = 2 * GRID_BITS;
    localparam logic [GRID_BITS-1:0] GRID_LAST = GRID_BITS'(GRID_SIZE - 1);

    // Word storage and length field.
    localparam int WORD_DEPTH = 16;
    localparam int WORD_BITS  = $clog2(WORD_DEPTH);
    localparam int LEN_W      = 5;
    localparam logic [LEN_W-1:0] GRID_SIZE_L  = LEN_W'(GRID_SIZE);
    localparam logic [LEN_W-1:0] WORD_DEPTH_L = LEN_W'(WORD_DEPTH);

    // Command codes.
    localparam logic [1:0] OP_GRID_WR = 2'd0;
    localparam logic [1:0] OP_WORD_WR = 2'd1;
    localparam logic [1:0] OP_SEARCH  = 2'd2;

    // Search directions in priority order.
    localparam logic [1:0] DIR_LR = 2'd0;
    localparam logic [1:0] DIR_RL = 2'd1;
    localparam logic [1:0] DIR_TB = 2'd2;
    localparam logic [1:0] DIR_BT = 2'd3;

    // Search command from the front end to the sequencer.
    typedef struct packed {
        logic             go;
        logic [LEN_W-1:0] len;
    } gws_cmd_t;

    // Sequencer status and finished result.
    typedef struct packed {
        logic                 idle;
        logic                 done;
        logic                 found;
        logic [1:0]           direction;
        logic [GRID_BITS-1:0] match_row;
        logic [GRID_BITS-1:0] match_col;
    } gws_stat_t;

endpackage

// ===== design/gws_in_if.sv =====
`timescale 1ns / 1ps

interface gws_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [3:0] row;
    logic [3:0] col;
    logic [3:0] word_index;
    logic [7:0] symbol;
    logic [4:0] word_length;

    modport source (
        output valid, opcode, row, col, word_index, symbol, word_length,
        input  ready
    );

    modport sink (
        input  valid, opcode, row, col, word_index, symbol, word_length,
        output ready
    );
endinterface

// ===== design/gws_out_if.sv =====
`timescale 1ns / 1ps

interface gws_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [1:0] direction;
    logic [3:0] match_row;
    logic [3:0] match_col;

    modport source (
        output valid, found, direction, match_row, match_col,
        input  ready
    );

    modport sink (
        input  valid, found, direction, match_row, match_col,
        output ready
    );
endinterface

// ===== design/gws_grid_ram.sv =====
`timescale 1ns / 1ps

module gws_grid_ram (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [gws_pkg::GRID_ADDR_W-1:0] wr_addr,
    input  logic [7:0]                    wr_data,
    input  logic                          rd_en,
    input  logic [gws_pkg::GRID_ADDR_W-1:0] rd_addr,
    output logic [7:0]                    rd_data
);
    import gws_pkg::*;

    logic [7:0] mem [GRID_SIZE*GRID_SIZE];

    // One write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // One registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== design/gws_seq.sv =====
`timescale 1ns / 1ps

module gws_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gws_pkg::gws_cmd_t             cmd,
    input  logic                          take,
    input  logic [7:0]                    letter,
    input  logic [7:0]                    grid_q,
    output logic [gws_pkg::WORD_BITS-1:0] letter_idx,
    output logic                          rd_en,
    output logic [gws_pkg::GRID_ADDR_W-1:0] rd_addr,
    output gws_pkg::gws_stat_t            stat
);
    import gws_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           dir_reg, dir_next;
    logic [GRID_BITS-1:0] line_reg, line_next;
    logic [GRID_BITS-1:0] start_reg, start_next;
    logic [GRID_BITS-1:0] last_start_reg, last_start_next;
    logic [WORD_BITS-1:0] k_reg, k_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [7:0]           expect_reg, expect_next;
    logic                 found_reg, found_next;
    logic [GRID_BITS-1:0] mrow_reg, mrow_next;
    logic [GRID_BITS-1:0] mcol_reg, mcol_next;

    logic [GRID_BITS:0]   pos_sum;
    logic [GRID_BITS-1:0] pos;
    logic [GRID_BITS-1:0] rd_r;
    logic [GRID_BITS-1:0] rd_c;
    logic [LEN_W-1:0]     len_m1;
    logic                 k_last;
    logic                 len_bad;

    // Cell position along the current line and its grid coordinate.
    assign pos_sum = {1'b0, start_reg} + (GRID_BITS+1)'(k_reg);
    assign pos     = pos_sum[GRID_BITS-1:0];

    always_comb
    begin
        unique case (dir_reg)
            DIR_LR:
            begin
                rd_r = line_reg;
                rd_c = pos;
            end
            DIR_RL:
            begin
                rd_r = line_reg;
                rd_c = GRID_LAST - pos;
            end
            DIR_TB:
            begin
                rd_r = pos;
                rd_c = line_reg;
            end
            default:
            begin
                rd_r = GRID_LAST - pos;
                rd_c = line_reg;
            end
        endcase
    end

    assign rd_addr    = {rd_r, rd_c};
    assign rd_en      = (state_reg == S_READ);
    assign letter_idx = k_reg;

    assign len_m1  = len_reg - LEN_W'(1);
    assign k_last  = (LEN_W'(k_reg) == len_m1);
    assign len_bad = (cmd.len == '0) || (cmd.len > WORD_DEPTH_L) || (cmd.len > GRID_SIZE_L);

    // Sequencer: one read and one letter compare per position step.
    always_comb
    begin
        state_next      = state_reg;
        dir_next        = dir_reg;
        line_next       = line_reg;
        start_next      = start_reg;
        last_start_next = last_start_reg;
        k_next          = k_reg;
        len_next        = len_reg;
        expect_next     = expect_reg;
        found_next      = found_reg;
        mrow_next       = mrow_reg;
        mcol_next       = mcol_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.go)
                begin
                    dir_next        = DIR_LR;
                    line_next       = '0;
                    start_next      = '0;
                    k_next          = '0;
                    len_next        = cmd.len;
                    last_start_next = GRID_BITS'(GRID_SIZE_L - cmd.len);
                    found_next      = 1'b0;
                    mrow_next       = '0;
                    mcol_next       = '0;
                    state_next      = len_bad ? S_DONE : S_READ;
                end
            end
            S_READ:
            begin
                expect_next = letter;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                if (grid_q == expect_reg)
                begin
                    if (k_last)
                    begin
                        found_next = 1'b1;
                        unique case (dir_reg)
                            DIR_LR:
                            begin
                                mrow_next = line_reg;
                                mcol_next = start_reg;
                            end
                            DIR_RL:
                            begin
                                mrow_next = line_reg;
                                mcol_next = GRID_LAST - start_reg;
                            end
                            DIR_TB:
                            begin
                                mrow_next = start_reg;
                                mcol_next = line_reg;
                            end
                            default:
                            begin
                                mrow_next = GRID_LAST - start_reg;
                                mcol_next = line_reg;
                            end
                        endcase
                        state_next = S_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + WORD_BITS'(1);
                        state_next = S_READ;
                    end
                end
                else
                begin
                    // Move to the next start, line or direction, or finish after the last direction.
                    k_next     = '0;
                    state_next = S_READ;
                    if (start_reg != last_start_reg)
                    begin
                        start_next = start_reg + GRID_BITS'(1);
                    end
                    else
                    begin
                        start_next = '0;
                        if (line_reg != GRID_LAST)
                        begin
                            line_next = line_reg + GRID_BITS'(1);
                        end
                        else
                        begin
                            line_next = '0;
                            if (dir_reg == DIR_BT)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                dir_next = dir_reg + 2'd1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dir_reg        <= DIR_LR;
            line_reg       <= '0;
            start_reg      <= '0;
            last_start_reg <= '0;
            k_reg          <= '0;
            len_reg        <= '0;
            expect_reg     <= '0;
            found_reg      <= 1'b0;
            mrow_reg       <= '0;
            mcol_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            dir_reg        <= dir_next;
            line_reg       <= line_next;
            start_reg      <= start_next;
            last_start_reg <= last_start_next;
            k_reg          <= k_next;
            len_reg        <= len_next;
            expect_reg     <= expect_next;
            found_reg      <= found_next;
            mrow_reg       <= mrow_next;
            mcol_reg       <= mcol_next;
        end
    end

    // A miss reports direction zero.
    always_comb
    begin
        stat.idle      = (state_reg == S_IDLE);
        stat.done      = (state_reg == S_DONE);
        stat.found     = found_reg;
        stat.direction = found_reg ? dir_reg : DIR_LR;
        stat.match_row = mrow_reg;
        stat.match_col = mcol_reg;
    end
endmodule

// ===== design/grid_word_search_four_dir_top.sv =====
`timescale 1ns / 1ps
// Channel  Role    Beat contents
// in_ch    sink    opcode, row, col, word_index, symbol, word_length
// out_ch   source  found, direction, match_row, match_col (one beat per search)
//
// Grid and word loads are taken while idle; a search drops ready from its start
// through its done state, reading each cell through the single grid read port
// and checking it against the word letter with one comparator.
// Reset is asynchronous and active low; grid and word contents are not cleared.
// A finished result waits in the output register while new beats are taken;
// a later search waits in its done state until that register is free.

module grid_word_search_four_dir_top (
    input  logic      clk,
    input  logic      rst_n,
    gws_in_if.sink    in_ch,
    gws_out_if.source out_ch
);
    import gws_pkg::*;

    gws_cmd_t             cmd;
    gws_stat_t            stat;
    logic                 take;
    logic                 in_fire;
    logic [7:0]           word_reg [WORD_DEPTH];
    logic [WORD_BITS-1:0] letter_idx;
    logic [7:0]           grid_q;
    logic                 rd_en;
    logic [GRID_ADDR_W-1:0] rd_addr;
    logic                 grid_wr;

    logic                 out_valid_reg;
    logic                 found_reg;
    logic [1:0]           direction_reg;
    logic [GRID_BITS-1:0] match_row_reg;
    logic [GRID_BITS-1:0] match_col_reg;

    // Input beats are taken only while the sequencer is idle.
    assign in_ch.ready = stat.idle;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign cmd.go  = in_fire && (in_ch.opcode == OP_SEARCH);
    assign cmd.len = in_ch.word_length;

    assign grid_wr = in_fire && (in_ch.opcode == OP_GRID_WR)
                     && ({1'b0, in_ch.row} < 5'(GRID_SIZE))
                     && ({1'b0, in_ch.col} < 5'(GRID_SIZE));

    // Word letters.
    always_ff @(posedge clk)
    begin
        if (in_fire && (in_ch.opcode == OP_WORD_WR))
        begin
            word_reg[in_ch.word_index] <= in_ch.symbol;
        end
    end

    gws_grid_ram u_grid (
        .clk     (clk),
        .wr_en   (grid_wr),
        .wr_addr ({in_ch.row[GRID_BITS-1:0], in_ch.col[GRID_BITS-1:0]}),
        .wr_data (in_ch.symbol),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (grid_q)
    );

    gws_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .take       (take),
        .letter     (word_reg[letter_idx]),
        .grid_q     (grid_q),
        .letter_idx (letter_idx),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .stat       (stat)
    );

    // Output register; a result moves in when the register is empty or draining.
    assign take = stat.done && (!out_valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            found_reg     <= stat.found;
            direction_reg <= stat.direction;
            match_row_reg <= stat.match_row;
            match_col_reg <= stat.match_col;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.found     = found_reg;
    assign out_ch.direction = direction_reg;
    assign out_ch.match_row = 4'(match_row_reg);
    assign out_ch.match_col = 4'(match_col_reg);

`include "grid_word_search_four_dir_top_assert.svh"

    `GWS_ASSERT_NEXT(a_search_leaves_idle, cmd.go, !stat.idle, "search did not start")
    `GWS_ASSERT_NEXT(a_done_holds, stat.done && !take, stat.done && $stable(stat.found) && $stable(stat.match_row) && $stable(stat.match_col), "finished result changed before hand-off")
    `GWS_ASSERT_NOW(a_miss_zero, out_ch.valid && !out_ch.found, out_ch.direction == DIR_LR && out_ch.match_row == '0 && out_ch.match_col == '0, "miss reported with nonzero fields")
endmodule
